/* rtl/quantized_channel_shuffle_top_assert.svh */
// ----------------------------------------------------------------------------
// Quantized channel shuffle assertion macros
// Shared assertion forms for the checker of the quantized channel shuffle.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_CHANNEL_SHUFFLE_TOP_ASSERT_SVH
`define QUANTIZED_CHANNEL_SHUFFLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define QCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define QCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/qcs_pkg.sv */
// ----------------------------------------------------------------------------
// Quantized channel shuffle package
// Widths, configuration register codes and the configuration record.
// ----------------------------------------------------------------------------
package qcs_pkg;

	localparam int CH_W       = 12;
	localparam int POS_W      = 16;
	localparam int VAL_W      = 8;
	localparam int FC_W       = 13;
	localparam int BIAS_W     = 9;
	localparam int GAIN_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int T_W        = 10;
	localparam int MAG_W      = 9;
	localparam int PROD_W     = 2 * GAIN_W;
	localparam int PART_W     = GAIN_W + MAG_W;
	localparam int Q_W        = 11;
	localparam int R_W        = 12;

	localparam logic [Q_W-1:0]    Q_MAX      = Q_W'(1024);
	localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
	localparam logic [PART_W:0]   ROUND_HALF = (PART_W + 1)'(64'h8000_0000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHUFFLE_TYPE   = 3'd0,
		REG_FIRST_CHANNELS = 3'd1,
		REG_BIAS_FIRST     = 3'd2,
		REG_BIAS_SECOND    = 3'd3,
		REG_NORM_FIRST     = 3'd4,
		REG_NORM_SECOND    = 3'd5,
		REG_OUT_SCALE      = 3'd6,
		REG_OUT_ZERO       = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                     shuffle_type;
		logic [FC_W-1:0]          first_channels;
		logic signed [BIAS_W-1:0] bias_first;
		logic signed [BIAS_W-1:0] bias_second;
		logic [GAIN_W-1:0]        norm_first;
		logic [GAIN_W-1:0]        norm_second;
		logic [GAIN_W-1:0]        out_scale;
		logic [VAL_W-1:0]         out_zero;
	} cfg_t;

endpackage

/* rtl/qcs_cfg.sv */
// ----------------------------------------------------------------------------
// Quantized channel shuffle configuration registers
// Decodes writes on the configuration port into the register record.
// ----------------------------------------------------------------------------
module qcs_cfg import qcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shuffle_type   <= 1'b0;
			cfg_q.first_channels <= '0;
			cfg_q.bias_first     <= '0;
			cfg_q.bias_second    <= '0;
			cfg_q.norm_first     <= GAIN_ONE;
			cfg_q.norm_second    <= GAIN_ONE;
			cfg_q.out_scale      <= GAIN_ONE;
			cfg_q.out_zero       <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SHUFFLE_TYPE:   cfg_q.shuffle_type   <= cfg_data[0];
				REG_FIRST_CHANNELS: cfg_q.first_channels <= cfg_data[FC_W-1:0];
				REG_BIAS_FIRST:     cfg_q.bias_first     <= cfg_data[BIAS_W-1:0];
				REG_BIAS_SECOND:    cfg_q.bias_second    <= cfg_data[BIAS_W-1:0];
				REG_NORM_FIRST:     cfg_q.norm_first     <= cfg_data[GAIN_W-1:0];
				REG_NORM_SECOND:    cfg_q.norm_second    <= cfg_data[GAIN_W-1:0];
				REG_OUT_SCALE:      cfg_q.out_scale      <= cfg_data[GAIN_W-1:0];
				REG_OUT_ZERO:       cfg_q.out_zero       <= cfg_data[VAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/quantized_channel_shuffle_top.sv */
// ----------------------------------------------------------------------------
// Quantized channel shuffle with requantization
// Four-stage pipeline that maps each element to its destination tensor and
// channel and requantizes its byte through the two gains and the zero point.
// ----------------------------------------------------------------------------
// The block accepts one item per clock and returns each result in order, as
// long as the output side keeps taking items. The stages form a multiplier
// chain: the first stage forms the 64-bit product of the source gain and the
// output scale, the second multiplies that by the magnitude of the biased value,
// the third rounds and clamps, and the fourth adds the result to, or subtracts
// it from, the zero point by the sign and saturates. A stall on the output fills
// the stages behind it and then holds the input side off.
module quantized_channel_shuffle_top import qcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  source_sel,
	input  logic [CH_W-1:0]       channel,
	input  logic [POS_W-1:0]      position,
	input  logic [VAL_W-1:0]      value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  dest_sel,
	output logic [CH_W-1:0]       dest_channel,
	output logic [POS_W-1:0]      dest_position,
	output logic [VAL_W-1:0]      result
);

	cfg_t cfg;

	qcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	logic [CH_W-1:0]          half;
	logic [CH_W-1:0]          ch_diff;
	logic                     dsel_c;
	logic [CH_W-1:0]          dch_c;
	logic signed [BIAS_W-1:0] bias_c;
	logic [GAIN_W-1:0]        norm_c;
	logic signed [T_W-1:0]    t_c;
	logic                     neg_c;
	logic [MAG_W-1:0]         mag_c;
	logic [PROD_W-1:0]        gain_c;

	assign half    = cfg.first_channels[FC_W-1:1];
	assign ch_diff = channel - half;

	always_comb begin
		if (!cfg.shuffle_type) begin
			dsel_c = channel[0];
			dch_c  = {1'b0, channel[CH_W-1:1]} + (source_sel ? half : '0);
		end else if (channel < half) begin
			dsel_c = 1'b0;
			dch_c  = {channel[CH_W-2:0], source_sel};
		end else begin
			dsel_c = 1'b1;
			dch_c  = {ch_diff[CH_W-2:0], source_sel};
		end
	end

	assign bias_c = source_sel ? cfg.bias_second : cfg.bias_first;
	assign norm_c = source_sel ? cfg.norm_second : cfg.norm_first;
	assign t_c    = $signed({2'b00, value}) + $signed({bias_c[BIAS_W-1], bias_c});
	assign neg_c  = t_c[T_W-1];
	assign mag_c  = neg_c ? MAG_W'(-t_c) : t_c[MAG_W-1:0];
	assign gain_c = PROD_W'(norm_c) * PROD_W'(cfg.out_scale);

	logic              dsel_s1, dsel_s2, dsel_s3, dsel_s4;
	logic [CH_W-1:0]   dch_s1, dch_s2, dch_s3, dch_s4;
	logic [POS_W-1:0]  pos_s1, pos_s2, pos_s3, pos_s4;
	logic              neg_s1, neg_s2, neg_s3;
	logic [MAG_W-1:0]  mag_s1;
	logic [PROD_W-1:0] gain_s1;
	logic [PART_W-1:0] p_hi_s2, p_lo_s2;
	logic [Q_W-1:0]    q_s3;
	logic [VAL_W-1:0]  res_s4;

	logic [PART_W:0]       lo_rnd_c;
	logic [PART_W:0]       sum_c;
	logic [Q_W-1:0]        q_c;
	logic signed [R_W-1:0] r_c;
	logic [VAL_W-1:0]      res_c;

	assign lo_rnd_c = (PART_W + 1)'(p_lo_s2) + ROUND_HALF;
	assign sum_c    = (PART_W + 1)'(p_hi_s2) + (PART_W + 1)'(lo_rnd_c[PART_W:GAIN_W]);
	assign q_c      = (sum_c > (PART_W + 1)'(Q_MAX)) ? Q_MAX : sum_c[Q_W-1:0];

	always_comb begin
		if (neg_s3) begin
			r_c = $signed(R_W'(cfg.out_zero)) - $signed(R_W'(q_s3));
		end else begin
			r_c = $signed(R_W'(cfg.out_zero)) + $signed(R_W'(q_s3));
		end
		if (r_c < 0) begin
			res_c = '0;
		end else if (r_c > $signed(R_W'(255))) begin
			res_c = '1;
		end else begin
			res_c = r_c[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dsel_s1 <= dsel_c;
			dch_s1  <= dch_c;
			pos_s1  <= position;
			neg_s1  <= neg_c;
			mag_s1  <= mag_c;
			gain_s1 <= gain_c;
		end
		if (en_s2) begin
			dsel_s2 <= dsel_s1;
			dch_s2  <= dch_s1;
			pos_s2  <= pos_s1;
			neg_s2  <= neg_s1;
			p_hi_s2 <= PART_W'(mag_s1) * PART_W'(gain_s1[PROD_W-1:GAIN_W]);
			p_lo_s2 <= PART_W'(mag_s1) * PART_W'(gain_s1[GAIN_W-1:0]);
		end
		if (en_s3) begin
			dsel_s3 <= dsel_s2;
			dch_s3  <= dch_s2;
			pos_s3  <= pos_s2;
			neg_s3  <= neg_s2;
			q_s3    <= q_c;
		end
		if (en_s4) begin
			dsel_s4 <= dsel_s3;
			dch_s4  <= dch_s3;
			pos_s4  <= pos_s3;
			res_s4  <= res_c;
		end
	end

	assign out_valid     = valid_s4;
	assign dest_sel      = dsel_s4;
	assign dest_channel  = dch_s4;
	assign dest_position = pos_s4;
	assign result        = res_s4;

endmodule

/* rtl/qcs_checker.sv */
// ----------------------------------------------------------------------------
// Quantized channel shuffle port checker
// Watches the ports of the top level for flow and latency properties.
// ----------------------------------------------------------------------------
`include "quantized_channel_shuffle_top_assert.svh"

module qcs_checker import qcs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             dest_sel,
	input logic [CH_W-1:0]  dest_channel,
	input logic [POS_W-1:0] dest_position,
	input logic [VAL_W-1:0] result
);

	`QCS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(dest_sel) && $stable(dest_channel) && $stable(dest_position) && $stable(result), "Stalled item changed.")
	`QCS_ASSERT_IMP(a_flow, out_ready, in_ready, "Input held off while output drains.")
	`QCS_ASSERT_IMP(a_full, !in_ready, out_valid && !out_ready, "Input held off without output stall.")
	`QCS_ASSERT_NXT(a_latency, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "Item missing after four cycles.")

endmodule

bind quantized_channel_shuffle_top qcs_checker u_qcs_checker (.*);

/* sim/tb_quantized_channel_shuffle_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quantized channel shuffle testbench
// Streams elements through the shuffle under many register settings, with
// random gaps on the input and random stalls on the output. A local predictor
// works out the destination and the requantized byte of every accepted item,
// and each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_quantized_channel_shuffle_top;
	import qcs_pkg::*;

	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1500;

	typedef struct {
		logic             dest_sel;
		logic [CH_W-1:0]  dest_channel;
		logic [POS_W-1:0] dest_position;
		logic [VAL_W-1:0] result;
	} shuffle_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  source_sel = 1'b0;
	logic [CH_W-1:0]       channel = '0;
	logic [POS_W-1:0]      position = '0;
	logic [VAL_W-1:0]      value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  dest_sel;
	logic [CH_W-1:0]       dest_channel;
	logic [POS_W-1:0]      dest_position;
	logic [VAL_W-1:0]      result;

	cfg_t         shuffle_cfg;
	shuffle_out_t expected_outputs[$];
	int           errors = 0;
	int           idle_count = 0;
	bit           idle_enable = 1'b0;
	bit           stall_enable = 1'b0;

	quantized_channel_shuffle_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.source_sel(source_sel),
		.channel(channel),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dest_sel(dest_sel),
		.dest_channel(dest_channel),
		.dest_position(dest_position),
		.result(result)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [VAL_W-1:0] requantize(input logic [VAL_W-1:0] v,
			input logic signed [BIAS_W-1:0] bias, input logic [GAIN_W-1:0] norm);
		int          t;
		logic [63:0] mag;
		logic [63:0] gain;
		logic [63:0] q;
		longint      r;
		t = int'(v) + int'(bias);
		mag = 64'(t < 0 ? -t : t);
		gain = {32'b0, norm} * {32'b0, shuffle_cfg.out_scale};
		q = mag * {32'b0, gain[63:32]} + ((mag * {32'b0, gain[31:0]} + 64'h8000_0000) >> 32);
		if (q > 64'd1024)
			q = 64'd1024;
		if (t < 0)
			r = longint'(shuffle_cfg.out_zero) - longint'(q);
		else
			r = longint'(shuffle_cfg.out_zero) + longint'(q);
		if (r < 0)
			r = 0;
		if (r > 255)
			r = 255;
		return r[VAL_W-1:0];
	endfunction

	function automatic shuffle_out_t predict_output(input logic src, input logic [CH_W-1:0] ch,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		shuffle_out_t o;
		logic [CH_W-1:0] half;
		logic [31:0] dch;
		half = shuffle_cfg.first_channels[FC_W-1:1];
		if (shuffle_cfg.shuffle_type == 1'b0) begin
			o.dest_sel = ch[0];
			dch = 32'(ch >> 1) + (src ? 32'(half) : 32'd0);
		end else if (ch < half) begin
			o.dest_sel = 1'b0;
			dch = 2 * 32'(ch) + 32'(src);
		end else begin
			o.dest_sel = 1'b1;
			dch = 2 * (32'(ch) - 32'(half)) + 32'(src);
		end
		o.dest_channel = dch[CH_W-1:0];
		o.dest_position = pos;
		if (src)
			o.result = requantize(val, shuffle_cfg.bias_second, shuffle_cfg.norm_second);
		else
			o.result = requantize(val, shuffle_cfg.bias_first, shuffle_cfg.norm_first);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < 100)
			$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_item(input logic src, input logic [CH_W-1:0] ch,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		int gap;
		bit taken;
		gap = idle_enable ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		source_sel <= src;
		channel <= ch;
		position <= pos;
		value <= val;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		expected_outputs.push_back(predict_output(src, ch, pos, val));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_SHUFFLE_TYPE:   shuffle_cfg.shuffle_type = data[0];
			REG_FIRST_CHANNELS: shuffle_cfg.first_channels = data[FC_W-1:0];
			REG_BIAS_FIRST:     shuffle_cfg.bias_first = data[BIAS_W-1:0];
			REG_BIAS_SECOND:    shuffle_cfg.bias_second = data[BIAS_W-1:0];
			REG_NORM_FIRST:     shuffle_cfg.norm_first = data;
			REG_NORM_SECOND:    shuffle_cfg.norm_second = data;
			REG_OUT_SCALE:      shuffle_cfg.out_scale = data;
			REG_OUT_ZERO:       shuffle_cfg.out_zero = data[VAL_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic st, input logic [FC_W-1:0] fc,
			input logic signed [BIAS_W-1:0] bf, input logic signed [BIAS_W-1:0] bs,
			input logic [GAIN_W-1:0] nf, input logic [GAIN_W-1:0] ns,
			input logic [GAIN_W-1:0] sc, input logic [VAL_W-1:0] z);
		wait_idle();
		write_reg(REG_SHUFFLE_TYPE, 32'({st}));
		write_reg(REG_FIRST_CHANNELS, 32'({fc}));
		write_reg(REG_BIAS_FIRST, 32'({bf}));
		write_reg(REG_BIAS_SECOND, 32'({bs}));
		write_reg(REG_NORM_FIRST, nf);
		write_reg(REG_NORM_SECOND, ns);
		write_reg(REG_OUT_SCALE, sc);
		write_reg(REG_OUT_ZERO, 32'({z}));
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [BIAS_W-1:0] pick_bias();
		case ($urandom_range(0, 7))
			0:       return -9'sd256;
			1:       return 9'sd255;
			2:       return -9'sd255;
			default: return BIAS_W'(int'($urandom_range(0, 510)) - 255);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom();
			3:       return GAIN_ONE;
			default: return $urandom_range(1 << 13, 1 << 19);
		endcase
	endfunction

	task automatic random_config();
		logic [FC_W-1:0] fc;
		logic [VAL_W-1:0] z;
		case ($urandom_range(0, 9))
			0:       fc = '0;
			1:       fc = 13'd4096;
			2:       fc = FC_W'($urandom_range(4097, 8191));
			3:       fc = FC_W'($urandom_range(0, 4095) * 2 + 1);
			default: fc = FC_W'($urandom_range(0, 2048) * 2);
		endcase
		case ($urandom_range(0, 5))
			0:       z = '0;
			1:       z = 8'hFF;
			default: z = VAL_W'($urandom_range(0, 255));
		endcase
		configure(1'($urandom_range(0, 1)), fc, pick_bias(), pick_bias(), pick_gain(),
			pick_gain(), pick_gain(), z);
	endtask

	task automatic test_reset_config();
		send_item(1'b0, 12'd0, 16'd0, 8'd0);
		send_item(1'b1, 12'd4095, 16'd65535, 8'd255);
		send_item(1'b0, 12'd1, 16'd1, 8'd128);
		send_item(1'b1, 12'd2, 16'd32768, 8'd1);
	endtask

	task automatic test_split_mode();
		configure(1'b0, 13'd7, -9'sd255, 9'sd255, GAIN_ONE, GAIN_ONE, GAIN_ONE, 8'd128);
		send_item(1'b0, 12'd4095, 16'd100, 8'd0);
		send_item(1'b1, 12'd4095, 16'd200, 8'd255);
		send_item(1'b1, 12'd0, 16'd300, 8'd17);
		send_item(1'b0, 12'd6, 16'd400, 8'd240);
	endtask

	task automatic test_interleave_mode();
		configure(1'b1, 13'd4096, 9'sd0, 9'sd0, GAIN_ONE, GAIN_ONE, GAIN_ONE, 8'd0);
		send_item(1'b0, 12'd2047, 16'd5, 8'd10);
		send_item(1'b1, 12'd2047, 16'd6, 8'd20);
		send_item(1'b0, 12'd2048, 16'd7, 8'd30);
		send_item(1'b1, 12'd4095, 16'd8, 8'd40);
		// An odd count with the widest half makes the destination channel wrap.
		configure(1'b1, 13'd8191, 9'sd1, -9'sd1, GAIN_ONE, GAIN_ONE, GAIN_ONE, 8'd50);
		send_item(1'b1, 12'd4094, 16'd9, 8'd60);
		send_item(1'b0, 12'd4095, 16'd10, 8'd70);
		configure(1'b1, 13'd0, 9'sd0, 9'sd0, GAIN_ONE, GAIN_ONE, GAIN_ONE, 8'd0);
		send_item(1'b1, 12'd100, 16'd11, 8'd80);
	endtask

	task automatic test_gain_extremes();
		// Half gains put the scaled value exactly on a tie in both directions.
		configure(1'b0, 13'd0, 9'sd0, -9'sd1, 32'h0000_8000, 32'h0000_8000, GAIN_ONE, 8'd100);
		send_item(1'b0, 12'd0, 16'd0, 8'd1);
		send_item(1'b1, 12'd1, 16'd1, 8'd0);
		send_item(1'b0, 12'd2, 16'd2, 8'd3);
		configure(1'b0, 13'd0, -9'sd256, 9'sd255, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'd7);
		send_item(1'b0, 12'd3, 16'd3, 8'd0);
		send_item(1'b0, 12'd4, 16'd4, 8'd255);
		send_item(1'b1, 12'd5, 16'd5, 8'd200);
	endtask

	task automatic test_random_traffic();
		int sent;
		int phase_len;
		int half;
		logic [CH_W-1:0] ch;
		sent = 0;
		phase_len = 0;
		while (sent < RANDOM_ITEMS) begin
			random_config();
			idle_enable = (sent == 0) ? 1'b0 : bit'($urandom_range(0, 3) != 0);
			stall_enable = (sent == 0) ? 1'b0 : bit'($urandom_range(0, 3) != 0);
			phase_len = $urandom_range(60, 240);
			half = int'(shuffle_cfg.first_channels >> 1);
			repeat (phase_len) begin
				if ($urandom_range(0, 7) == 0)
					ch = CH_W'(half + int'($urandom_range(0, 4)) - 2);
				else
					ch = CH_W'($urandom_range(0, 4095));
				send_item(1'($urandom_range(0, 1)), ch, POS_W'($urandom_range(0, 65535)),
					VAL_W'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	initial begin : out_ready_drive
		int run;
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			run = $urandom_range(1, 20);
			repeat (run) @(posedge clk);
			stall = stall_enable ? pick_gap() : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(negedge clk) begin : check_output
		shuffle_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_outputs.size() == 0) begin
				report_mismatch("item with nothing expected, result", 32'(result), 0);
			end else begin
				want = expected_outputs.pop_front();
				if (dest_sel !== want.dest_sel)
					report_mismatch("dest_sel", 32'(dest_sel), 32'(want.dest_sel));
				if (dest_channel !== want.dest_channel)
					report_mismatch("dest_channel", 32'(dest_channel), 32'(want.dest_channel));
				if (dest_position !== want.dest_position)
					report_mismatch("dest_position", 32'(dest_position),
						32'(want.dest_position));
				if (result !== want.result)
					report_mismatch("result", 32'(result), 32'(want.result));
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("FAIL quantized_channel_shuffle_top");
			$finish;
		end
	end

	initial begin
		shuffle_cfg = '{shuffle_type: 1'b0, first_channels: '0, bias_first: '0,
			bias_second: '0, norm_first: GAIN_ONE, norm_second: GAIN_ONE,
			out_scale: GAIN_ONE, out_zero: '0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_split_mode();
		test_interleave_mode();
		test_gain_extremes();
		test_random_traffic();
		wait_idle();
		if (errors == 0)
			$display("PASS quantized_channel_shuffle_top");
		else
			$display("FAIL quantized_channel_shuffle_top");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/qcs_pkg.sv
rtl/qcs_cfg.sv
rtl/quantized_channel_shuffle_top.sv
rtl/qcs_checker.sv
sim/tb_quantized_channel_shuffle_top.sv
